// ===== rtl/mbc_pkg.sv =====
// Package for the band-limited step/ramp correction mixer.
// Holds opcodes, register indexes, reset values and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package mbc_pkg;

  localparam int unsigned MaxSlotsDef   = 16;
  localparam int unsigned TableDepthDef = 512;

  typedef enum logic [1:0] {
    OP_PASS       = 2'd0,
    OP_ADD_BLEP   = 2'd1,
    OP_WRITE_STEP = 2'd2,
    OP_WRITE_RAMP = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_OVERSAMPLING = 2'd0,
    REG_FREQ_PROP    = 2'd1,
    REG_TABLE_LENGTH = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_index_e;

  localparam int unsigned CfgDataW   = 17;
  localparam int unsigned SampleW    = 24;
  localparam int unsigned TabValW    = 18;
  localparam int unsigned TabAddrW   = 9;
  localparam int unsigned IncW       = 23;
  localparam int unsigned MulW       = 24;

  localparam logic [6:0]  RatioReset   = 7'd16;
  localparam logic [16:0] FreqReset    = 17'd32768;
  localparam int unsigned TabLenReset  = 512;

endpackage

// ===== rtl/mbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mbc_ram #(
  parameter int unsigned Width = 18,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/minblep_blamp_correction_mixer.sv =====
// Band-limited step/ramp correction mixer: top level with sequencer and shared multiplier.
// Depends on mbc_pkg and mbc_ram (two table memories).
// Table writes finish in idle. An add runs INC, PMUL, then SCAN up to a free slot; a pass
// runs INC, then per slot CHK, NEXT (free), CHK, ADV, NEXT (outside table) or CHK, RD1,
// RD2, M1-M4, ADV, NEXT (mixing), then FIN. One slot at a time uses one 24x24 multiplier and
// one read port per table. Ready only while idle; a result waits in the output register.
// Reset (rst_ni low, async) frees all slots, restores registers; table contents undefined.
`timescale 1ns / 1ps

module minblep_blamp_correction_mixer
  import mbc_pkg::*;
#(
  parameter int unsigned MAX_SLOTS   = MaxSlotsDef,
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // config write port
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [16:0]   cfg_data_i,
  // input stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [23:0] sample_in, [32:24] table_address, [50:33] table_value,
  // [66:51] start_position, [82:67] position_gain, [98:83] velocity_gain, rest zero
  input  logic [103:0]  s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]    s_axis_tuser,
  // output stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [23:0] sample_out, [28:24] active_slots, rest zero
  output logic [31:0]   m_axis_tdata,
  // [0] clipped
  output logic [0:0]    m_axis_tuser
);

  // Sizes
  localparam int unsigned AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned LEN_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PH_W   = (AW + 18 > 26) ? AW + 18 : 26;
  localparam int unsigned IW     = PH_W - 16;
  localparam int unsigned SW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned ACC_W  = 38 + $clog2(MAX_SLOTS + 1);
  localparam int unsigned LEN_RST = (TabLenReset > TABLE_DEPTH) ? TABLE_DEPTH : TabLenReset;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INC  = 4'd1;
  localparam logic [3:0] S_PMUL = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_RD1  = 4'd5;
  localparam logic [3:0] S_RD2  = 4'd6;
  localparam logic [3:0] S_M1   = 4'd7;
  localparam logic [3:0] S_M2   = 4'd8;
  localparam logic [3:0] S_M3   = 4'd9;
  localparam logic [3:0] S_M4   = 4'd10;
  localparam logic [3:0] S_ADV  = 4'd11;
  localparam logic [3:0] S_NEXT = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  logic [3:0] state_q, state_d;

  // Config registers
  logic [6:0]       ratio_q;
  logic [16:0]      freq_q;
  logic [LEN_W-1:0] tlen_q;

  // Latched item fields
  logic [1:0]         op_q;
  logic [SampleW-1:0] sample_q;
  logic [15:0]        start_q, pgain_q, vgain_q;

  // Slot state
  logic                   slot_act_q [MAX_SLOTS];
  logic signed [PH_W-1:0] slot_ph_q  [MAX_SLOTS];
  logic signed [15:0]     slot_pg_q  [MAX_SLOTS];
  logic signed [15:0]     slot_vg_q  [MAX_SLOTS];

  // Work registers
  logic [SW-1:0]           slot_q;
  logic [CNT_W-1:0]        count_q;
  logic [IncW-1:0]         inc_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [TabValW-1:0] bef_s_q, bef_r_q;
  logic signed [18:0]      v_s_q, v_r_q;
  logic signed [2*MulW-1:0] prod_q;

  // Output register
  logic               m_valid_q;
  logic [31:0]        m_data_q;
  logic               m_clip_q;

  // Handshakes
  logic in_fire, out_fire;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  // Table write path
  logic [15:0]        waddr_ext;
  logic               addr_ok;
  logic               we_step, we_ramp;
  assign waddr_ext = 16'(s_axis_tdata[32:24]);
  assign addr_ok   = waddr_ext < 16'(TABLE_DEPTH);
  assign we_step   = in_fire && (s_axis_tuser == OP_WRITE_STEP) && addr_ok;
  assign we_ramp   = in_fire && (s_axis_tuser == OP_WRITE_RAMP) && addr_ok;

  // Current slot view
  logic signed [PH_W-1:0] ph_cur;
  logic [IW-1:0]          idx_cur, idx_nxt;
  logic [15:0]            frac_cur;
  logic                   in_range;
  logic [AW-1:0]          raddr;
  logic [TabValW-1:0]     rd_step, rd_ramp;

  assign ph_cur   = slot_ph_q[slot_q];
  assign idx_cur  = ph_cur[PH_W-1:16];
  assign frac_cur = ph_cur[15:0];
  assign in_range = !ph_cur[PH_W-1] && (idx_cur < IW'(tlen_q));
  // last valid entry interpolates against itself
  assign idx_nxt  = ((idx_cur + IW'(1)) < IW'(tlen_q)) ? idx_cur + IW'(1) : idx_cur;
  assign raddr    = (state_q == S_CHK) ? idx_cur[AW-1:0] : idx_nxt[AW-1:0];

  mbc_ram #(.Width(TabValW), .Depth(TABLE_DEPTH)) u_step_ram (
    .clk_i   (clk_i),
    .we_i    (we_step),
    .waddr_i (waddr_ext[AW-1:0]),
    .wdata_i (s_axis_tdata[50:33]),
    .raddr_i (raddr),
    .rdata_o (rd_step)
  );

  mbc_ram #(.Width(TabValW), .Depth(TABLE_DEPTH)) u_ramp_ram (
    .clk_i   (clk_i),
    .we_i    (we_ramp),
    .waddr_i (waddr_ext[AW-1:0]),
    .wdata_i (s_axis_tdata[50:33]),
    .raddr_i (raddr),
    .rdata_o (rd_ramp)
  );

  // Shared multiplier, operands chosen by state
  logic signed [MulW-1:0] mul_a, mul_b;
  logic                   mul_en;
  logic signed [18:0]     diff_s, diff_r;

  assign diff_s = {rd_step[17], rd_step} - {bef_s_q[17], bef_s_q};
  assign diff_r = {rd_ramp[17], rd_ramp} - {bef_r_q[17], bef_r_q};

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        mul_a  = MulW'(ratio_q);
        mul_b  = MulW'(freq_q);
        mul_en = in_fire;
      end
      S_PMUL: begin
        mul_a  = {{(MulW-16){start_q[15]}}, start_q};
        mul_b  = MulW'(inc_q);
        mul_en = 1'b1;
      end
      S_RD2: begin
        mul_a  = {{(MulW-19){diff_s[18]}}, diff_s};
        mul_b  = MulW'(frac_cur);
        mul_en = 1'b1;
      end
      S_M1: begin
        mul_a  = {{(MulW-19){diff_r[18]}}, diff_r};
        mul_b  = MulW'(frac_cur);
        mul_en = 1'b1;
      end
      S_M2: begin
        mul_a  = {{(MulW-19){v_s_q[18]}}, v_s_q};
        mul_b  = {{(MulW-16){slot_pg_q[slot_q][15]}}, slot_pg_q[slot_q]};
        mul_en = 1'b1;
      end
      S_M3: begin
        mul_a  = {{(MulW-19){v_r_q[18]}}, v_r_q};
        mul_b  = {{(MulW-16){slot_vg_q[slot_q][15]}}, slot_vg_q[slot_q]};
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // Phase advance and slot end
  logic signed [PH_W-1:0] ph_adv, ph_end;
  logic signed [2*MulW-1:0] ph_reg_w;
  assign ph_adv   = ph_cur + PH_W'(inc_q);
  assign ph_end   = PH_W'({tlen_q, 16'h0000});
  assign ph_reg_w = prod_q >>> 14;

  // Final rounding and saturation
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-6:0] res_w;
  logic                    sat_hi, sat_lo;
  logic [SampleW-1:0]      res_sat;
  logic [4:0]              cnt_out;

  assign acc_rnd = acc_q + ACC_W'(16);
  assign res_w   = acc_rnd[ACC_W-1:5];
  assign sat_hi  = res_w > (ACC_W-5)'(8388607);
  assign sat_lo  = res_w < -(ACC_W-5)'(8388608);
  assign res_sat = sat_hi ? 24'h7FFFFF : (sat_lo ? 24'h800000 : res_w[SampleW-1:0]);
  assign cnt_out = (32'(count_q) > 32'd31) ? 5'd31 : 5'(count_q);

  logic last_slot;
  assign last_slot = (slot_q == SW'(MAX_SLOTS - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire && !s_axis_tuser[1]) state_d = S_INC;
      S_INC:  state_d = (op_q == OP_ADD_BLEP) ? S_PMUL : S_CHK;
      S_PMUL: state_d = S_SCAN;
      S_SCAN: if (!slot_act_q[slot_q] || last_slot) state_d = S_IDLE;
      S_CHK: begin
        if (!slot_act_q[slot_q]) state_d = S_NEXT;
        else if (in_range)       state_d = S_RD1;
        else                     state_d = S_ADV;
      end
      S_RD1:  state_d = S_RD2;
      S_RD2:  state_d = S_M1;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3:   state_d = S_M4;
      S_M4:   state_d = S_ADV;
      S_ADV:  state_d = S_NEXT;
      S_NEXT: state_d = last_slot ? S_FIN : S_CHK;
      S_FIN:  if (!m_valid_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ratio_q   <= RatioReset;
      freq_q    <= FreqReset;
      tlen_q    <= LEN_W'(LEN_RST);
      m_valid_q <= 1'b0;
      slot_q    <= '0;
      count_q   <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_act_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_OVERSAMPLING: begin
            if (cfg_data_i[6:0] < 7'd1)       ratio_q <= 7'd1;
            else if (cfg_data_i[6:0] > 7'd64) ratio_q <= 7'd64;
            else                              ratio_q <= cfg_data_i[6:0];
          end
          REG_FREQ_PROP: begin
            if (cfg_data_i < 17'd7)          freq_q <= 17'd7;
            else if (cfg_data_i > 17'd65536) freq_q <= 17'd65536;
            else                             freq_q <= cfg_data_i;
          end
          REG_TABLE_LENGTH: begin
            if (cfg_data_i[9:0] < 10'd16)
              tlen_q <= LEN_W'(16);
            else if (14'(cfg_data_i[9:0]) > 14'(LEN_RST))
              tlen_q <= LEN_W'(LEN_RST);
            else
              tlen_q <= LEN_W'(cfg_data_i[9:0]);
          end
          REG_UNUSED: begin
            tlen_q <= tlen_q;
          end
          default: begin
            tlen_q <= tlen_q;
          end
        endcase
      end

      // a new result may load in the cycle the held one is taken
      if ((state_q == S_FIN) && (!m_valid_q || m_axis_tready)) m_valid_q <= 1'b1;
      else if (out_fire)                                       m_valid_q <= 1'b0;

      unique case (state_q)
        S_INC: begin
          slot_q  <= '0;
          count_q <= '0;
        end
        S_SCAN: begin
          if (!slot_act_q[slot_q]) slot_act_q[slot_q] <= 1'b1;
          else if (!last_slot)     slot_q <= slot_q + SW'(1);
        end
        S_ADV: begin
          if (ph_adv >= ph_end) slot_act_q[slot_q] <= 1'b0;
          else                  count_q <= count_q + CNT_W'(1);
        end
        S_NEXT: begin
          if (!last_slot) slot_q <= slot_q + SW'(1);
        end
        default: begin
          slot_q <= slot_q;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= s_axis_tuser;
      sample_q <= s_axis_tdata[23:0];
      start_q  <= s_axis_tdata[66:51];
      pgain_q  <= s_axis_tdata[82:67];
      vgain_q  <= s_axis_tdata[98:83];
    end
    unique case (state_q)
      S_INC: begin
        inc_q <= prod_q[IncW-1:0];
        acc_q <= {{(ACC_W-29){sample_q[23]}}, sample_q, 5'b00000};
      end
      S_SCAN: begin
        if (!slot_act_q[slot_q]) begin
          slot_ph_q[slot_q] <= PH_W'(ph_reg_w);
          slot_pg_q[slot_q] <= pgain_q;
          slot_vg_q[slot_q] <= vgain_q;
        end
      end
      S_RD1: begin
        bef_s_q <= rd_step;
        bef_r_q <= rd_ramp;
      end
      S_M1: v_s_q <= {bef_s_q[17], bef_s_q} + prod_q[34:16];
      S_M2: v_r_q <= {bef_r_q[17], bef_r_q} + prod_q[34:16];
      S_M3: acc_q <= acc_q + ACC_W'(prod_q);
      S_M4: acc_q <= acc_q + ACC_W'(prod_q);
      S_ADV: begin
        slot_ph_q[slot_q] <= (ph_adv >= ph_end) ? '0 : ph_adv;
      end
      S_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_q <= {3'b000, cnt_out, res_sat};
          m_clip_q <= sat_hi || sat_lo;
        end
      end
      default: begin
        v_s_q <= v_s_q;
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_clip_q;

endmodule

// ===== rtl/mbc_checker.sv =====
// Port-level checker for the correction mixer, bound to the top level.
// Depends on mbc_pkg.
`timescale 1ns / 1ps

module mbc_checker
  import mbc_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MaxSlotsDef
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [31:0]  m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);

  // result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // sample or discontinuity transfer keeps the block busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser[1] |=> !s_axis_tready)
    else $error("ready while slot walk should run");

  // slot count never exceeds the slot store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(m_axis_tdata[28:24]) <= MAX_SLOTS)
    else $error("active slot count out of range");

  // clip flag only with a rail value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[23:0] == 24'h7FFFFF || m_axis_tdata[23:0] == 24'h800000)
    else $error("clip flag without saturated sample");

endmodule

bind minblep_blamp_correction_mixer mbc_checker #(.MAX_SLOTS(MAX_SLOTS)) u_mbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_minblep_blamp_correction_mixer.sv =====
// Self-checking testbench for minblep_blamp_correction_mixer: table loads, discontinuity
// registration and corrected samples checked against an in-bench fixed-point predictor.
// Depends on mbc_pkg and the RTL of the mixer only.
`timescale 1ns / 1ps

module tb_minblep_blamp_correction_mixer;
  import mbc_pkg::*;

  localparam int NSlots    = 16;
  localparam int Depth     = 512;
  localparam int SettleCyc = 200;    // worst pass: every slot mixing, plus margin
  localparam int StallCyc  = 400;    // long receiver hold-off
  localparam int WdogLimit = 20000;  // idle cycles before the run is declared hung

  // one input transfer, unpacked
  typedef struct {
    opcode_e            op;
    logic signed [23:0] sample;
    logic [8:0]         addr;
    logic signed [17:0] tval;
    logic signed [15:0] start_pos;
    logic signed [15:0] pos_gain;
    logic signed [15:0] vel_gain;
  } mix_item_t;

  // one output transfer
  typedef struct {
    logic [23:0] sample_out;
    logic        clipped;
    logic [4:0]  active_slots;
  } mix_out_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_index_i = '0;
  logic [16:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  minblep_blamp_correction_mixer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Mixer state as the predictor sees it
  // ---------------------------------------------------------------------------
  logic [6:0]         os_ratio;
  logic [16:0]        fprop;
  logic [9:0]         tab_len;
  logic               blep_on    [NSlots];
  longint             blep_phase [NSlots];  // Q.16 table entries, signed
  logic signed [15:0] blep_pg    [NSlots];
  logic signed [15:0] blep_vg    [NSlots];
  logic signed [17:0] step_tab   [Depth];
  logic signed [17:0] ramp_tab   [Depth];

  mix_item_t pending_q[$];   // items waiting for the driver
  mix_out_t  sample_exp_q[$]; // corrected samples not yet seen
  mix_item_t cur_item;
  int        errors = 0;
  bit        quiet = 1'b0;   // no idling on either side while set
  int        stall_req = 0;  // bumped to ask the receiver for a long hold-off

  function automatic longint phase_step();
    return longint'(os_ratio) * longint'(fprop);
  endfunction

  // linear interpolation between neighbouring entries, zero outside the table
  function automatic longint interp(input bit use_ramp, input longint phase);
    longint idx, frac, lo, hi;
    idx  = phase >>> 16;
    frac = phase & 64'hFFFF;
    if (idx >= longint'(tab_len)) return 0;
    lo = use_ramp ? longint'(ramp_tab[idx]) : longint'(step_tab[idx]);
    hi = lo;
    if (idx + 1 < longint'(tab_len))
      hi = use_ramp ? longint'(ramp_tab[idx + 1]) : longint'(step_tab[idx + 1]);
    return lo + (((hi - lo) * frac) >>> 16);
  endfunction

  // apply one accepted transfer to the predicted state; queue the sample it yields
  task automatic mix_predict(input mix_item_t it);
    longint   acc, res, lim;
    int       cnt;
    mix_out_t r;
    case (it.op)
      OP_WRITE_STEP: step_tab[it.addr] = it.tval;
      OP_WRITE_RAMP: ramp_tab[it.addr] = it.tval;
      OP_ADD_BLEP: begin
        // first free slot wins; a full bank drops the discontinuity
        for (int i = 0; i < NSlots; i++) begin
          if (!blep_on[i]) begin
            blep_on[i]    = 1'b1;
            blep_phase[i] = (longint'(it.start_pos) * phase_step()) >>> 14;
            blep_pg[i]    = it.pos_gain;
            blep_vg[i]    = it.vel_gain;
            break;
          end
        end
      end
      default: begin
        acc = longint'(it.sample) * 32;
        cnt = 0;
        lim = longint'(tab_len) << 16;
        for (int i = 0; i < NSlots; i++) begin
          if (blep_on[i]) begin
            // negative phase: nothing yet, but it still advances
            if (blep_phase[i] >= 0) begin
              acc += interp(1'b0, blep_phase[i]) * longint'(blep_pg[i]);
              acc += interp(1'b1, blep_phase[i]) * longint'(blep_vg[i]);
            end
            blep_phase[i] += phase_step();
            if (blep_phase[i] >= lim) begin
              blep_on[i]    = 1'b0;
              blep_phase[i] = 0;
            end else begin
              cnt++;
            end
          end
        end
        res       = (acc + 16) >>> 5;
        r.clipped = 1'b0;
        if (res > 64'sd8388607) begin
          res = 8388607;
          r.clipped = 1'b1;
        end else if (res < -64'sd8388608) begin
          res = -8388608;
          r.clipped = 1'b1;
        end
        r.sample_out   = res[23:0];
        r.active_slots = (cnt > 31) ? 5'd31 : cnt[4:0];
        sample_exp_q.push_back(r);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: input changes on the falling edge, one item held until its transfer
  // ---------------------------------------------------------------------------
  bit in_xfer = 1'b0;

  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_xfer) begin
      if (pending_q.size() != 0 && (quiet || $urandom_range(99) >= 16)) begin
        cur_item      = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cur_item.op;
        s_axis_tdata  <= {5'b0, cur_item.vel_gain, cur_item.pos_gain, cur_item.start_pos,
                          cur_item.tval, cur_item.addr, cur_item.sample};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int stall_seen = 0;
  int stall_left = 0;

  always @(negedge clk_i) begin
    if (stall_req != stall_seen) begin
      stall_seen    = stall_req;
      stall_left    = StallCyc;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 16);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input transfers, compare on output transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    mix_out_t e;
    in_xfer <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) mix_predict(cur_item);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sample_exp_q.size() == 0) begin
        $error("unexpected output transfer: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        e = sample_exp_q.pop_front();
        if (m_axis_tdata[23:0] !== e.sample_out) begin
          $error("sample_out: expected %0d, got %0d", $signed(e.sample_out),
                 $signed(m_axis_tdata[23:0]));
          errors++;
        end
        if (m_axis_tdata[28:24] !== e.active_slots) begin
          $error("active_slots: expected %0d, got %0d", e.active_slots, m_axis_tdata[28:24]);
          errors++;
        end
        if (m_axis_tuser[0] !== e.clipped) begin
          $error("clipped: expected %0b, got %0b", e.clipped, m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  int idle_cnt = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cnt = 0;
    end else if (++idle_cnt >= WdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // register write, mirrored into the predictor with the block's clamping
  task automatic reg_write(input reg_index_e idx, input logic [16:0] val);
    int unsigned v;
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_OVERSAMPLING: begin
        v = val[6:0];
        os_ratio = (v < 1) ? 7'd1 : (v > 64) ? 7'd64 : v[6:0];
      end
      REG_FREQ_PROP: begin
        v = val;
        fprop = (v < 7) ? 17'd7 : (v > 65536) ? 17'd65536 : v[16:0];
      end
      REG_TABLE_LENGTH: begin
        v = val[9:0];
        tab_len = (v < 16) ? 10'd16 : (v > Depth) ? 10'(Depth) : v[9:0];
      end
      default: ;
    endcase
  endtask

  // wait until the block is idle: everything sent, every sample back, walk finished
  task automatic drain();
    wait (pending_q.size() == 0 && !s_axis_tvalid && sample_exp_q.size() == 0);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  function automatic mix_item_t noise_item(input opcode_e op);
    mix_item_t it;
    it.op        = op;
    it.sample    = 24'($urandom);
    it.addr      = 9'($urandom);
    it.tval      = 18'($urandom);
    it.start_pos = 16'($urandom);
    it.pos_gain  = 16'($urandom);
    it.vel_gain  = 16'($urandom);
    return it;
  endfunction

  // mostly samples and discontinuities; gains often kept small to avoid clipping
  function automatic mix_item_t rand_item();
    mix_item_t   it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55)      it = noise_item(OP_PASS);
    else if (pick < 80) it = noise_item(OP_ADD_BLEP);
    else if (pick < 90) it = noise_item(OP_WRITE_STEP);
    else                it = noise_item(OP_WRITE_RAMP);
    if ($urandom_range(1)) begin
      it.pos_gain = 16'($signed($urandom_range(2048)) - 1024);
      it.vel_gain = 16'($signed($urandom_range(2048)) - 1024);
      it.sample   = 24'($signed($urandom_range(4000000)) - 2000000);
    end
    if ($urandom_range(3) == 0) it.start_pos = 16'($signed($urandom_range(16384)) - 4096);
    return it;
  endfunction

  task automatic rand_burst(input int n);
    for (int k = 0; k < n; k++) pending_q.push_back(rand_item());
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    mix_item_t it;
    os_ratio = RatioReset;
    fprop    = FreqReset;
    tab_len  = 10'(TabLenReset);
    for (int i = 0; i < NSlots; i++) begin
      blep_on[i]    = 1'b0;
      blep_phase[i] = 0;
      blep_pg[i]    = '0;
      blep_vg[i]    = '0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // load every entry of both tables so no unwritten entry is ever read
    quiet = 1'b1;
    for (int a = 0; a < Depth; a++) begin
      it = noise_item(OP_WRITE_STEP);
      it.addr = 9'(a);
      pending_q.push_back(it);
      it = noise_item(OP_WRITE_RAMP);
      it.addr = 9'(a);
      pending_q.push_back(it);
    end
    drain();

    // directed: field extremes with default settings
    it = noise_item(OP_PASS); it.sample = 24'sh7FFFFF; pending_q.push_back(it);
    it = noise_item(OP_PASS); it.sample = -24'sh800000; pending_q.push_back(it);
    it = noise_item(OP_WRITE_STEP); it.addr = 9'd511; it.tval = 18'sh1FFFF;
    pending_q.push_back(it);
    it = noise_item(OP_WRITE_RAMP); it.addr = 9'd0; it.tval = -18'sh20000;
    pending_q.push_back(it);
    // step at the table start with full-scale positive gains
    it = noise_item(OP_ADD_BLEP); it.start_pos = 16'sd0;
    it.pos_gain = 16'sh7FFF; it.vel_gain = 16'sh7FFF; pending_q.push_back(it);
    // most negative start: waits in negative phase
    it = noise_item(OP_ADD_BLEP); it.start_pos = -16'sh8000;
    it.pos_gain = -16'sh8000; it.vel_gain = -16'sh8000; pending_q.push_back(it);
    // largest start lands well into the table
    it = noise_item(OP_ADD_BLEP); it.start_pos = 16'sh7FFF;
    it.pos_gain = 16'sd4096; it.vel_gain = -16'sd4096; pending_q.push_back(it);
    for (int k = 0; k < 6; k++) begin
      it = noise_item(OP_PASS); it.sample = (k[0]) ? 24'sh7FFFFF : -24'sh800000;
      pending_q.push_back(it);
    end
    // one more discontinuity than there are slots; those that find no free slot are dropped
    for (int k = 0; k < NSlots + 1; k++) pending_q.push_back(noise_item(OP_ADD_BLEP));
    it = noise_item(OP_PASS); pending_q.push_back(it);
    drain();
    quiet = 1'b0;

    // default settings, random traffic with one long receiver hold-off
    rand_burst(50);
    stall_req++;
    rand_burst(80);
    drain();

    // fastest advance: slots free after a few samples; shortest table
    reg_write(REG_OVERSAMPLING, 17'd64);
    reg_write(REG_FREQ_PROP, 17'd65536);
    reg_write(REG_TABLE_LENGTH, 17'd16);
    rand_burst(120);
    drain();

    // out-of-range values clamp; slowest advance leaves slots full, adds get dropped
    reg_write(REG_OVERSAMPLING, 17'd0);
    reg_write(REG_FREQ_PROP, 17'd0);
    reg_write(REG_TABLE_LENGTH, 17'd1023);
    quiet = 1'b1;  // long stretch with no idling on either side
    rand_burst(100);
    drain();
    quiet = 1'b0;

    // upper clamps on ratio and frequency, lower clamp on table length, then a random setting
    reg_write(REG_OVERSAMPLING, 17'd127);
    reg_write(REG_FREQ_PROP, 17'h1FFFF);
    reg_write(REG_TABLE_LENGTH, 17'd0);
    rand_burst(70);
    drain();

    reg_write(REG_OVERSAMPLING, 17'($urandom_range(64, 1)));
    reg_write(REG_FREQ_PROP, 17'($urandom_range(65536, 7)));
    reg_write(REG_TABLE_LENGTH, 17'($urandom_range(512, 16)));
    rand_burst(100);
    stall_req++;
    rand_burst(75);

    wait (pending_q.size() == 0 && !s_axis_tvalid && sample_exp_q.size() == 0);
    repeat (SettleCyc) @(negedge clk_i);
    if (sample_exp_q.size() != 0) begin
      $error("%0d corrected samples never arrived", sample_exp_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
